FILE: src/tlpt_pkg.sv
// Shared constants, codes and control types of the TCP listen port table.
package tlpt_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int HANDLER_BITS = 8;
   localparam int SLOT_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [HANDLER_BITS-1:0] handler_type;
   typedef logic [15:0] port_type;

   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_LISTEN = 2'd1;
   localparam logic [1:0] OP_LISTEN_ANY = 2'd2;
   localparam logic [1:0] OP_UNLISTEN = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_INVALID = 3'd1;
   localparam logic [2:0] ST_IN_USE = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_NO_EPHEMERAL = 3'd4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_EPH_FIRST = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EPH_LAST = CSR_INDEX_BITS'(1);

   localparam port_type EPH_FIRST_RESET = 16'd49152;
   localparam port_type EPH_LAST_RESET = 16'd65535;

   typedef struct packed {
      logic load_req;
      logic exec;
      logic walk_step;
      logic load_out;
   } tlpt_cmd_type;

   typedef struct packed {
      logic walk_start;
      logic walk_done;
      logic out_busy;
   } tlpt_stat_type;

endpackage

FILE: src/tlpt_req_if.sv
// Request channel: opcode, port and handler with valid/ready.
interface tlpt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] port_number;
   logic [7:0]  handler_id;

   modport source (output valid, output opcode, output port_number, output handler_id,
                   input ready);
   modport sink (input valid, input opcode, input port_number, input handler_id,
                 output ready);
endinterface

FILE: src/tlpt_rsp_if.sv
// Result channel: status, found handler and assigned port with valid/ready.
interface tlpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  found_handler;
   logic [15:0] assigned_port;

   modport source (output valid, output status, output found_handler, output assigned_port,
                   input ready);
   modport sink (input valid, input status, input found_handler, input assigned_port,
                 output ready);
endinterface

FILE: src/tlpt_ctrl.sv
// Sequencer of the listen port table: accept, execute, ephemeral walk, result hand-off.
module tlpt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tlpt_pkg::tlpt_stat_type stat,
   output tlpt_pkg::tlpt_cmd_type  cmd
);
   import tlpt_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_WALK = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = stat.walk_start ? S_WALK : S_DONE;
         end
         S_WALK: begin
            if (stat.walk_done) state_in = S_DONE;
         end
         S_DONE: begin
            if (!stat.out_busy) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign cmd.load_req = (state_ff == S_IDLE) && req_valid;
   assign cmd.exec = (state_ff == S_EXEC);
   assign cmd.walk_step = (state_ff == S_WALK);
   assign cmd.load_out = (state_ff == S_DONE) && !stat.out_busy;

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item accepted while another is in flight");

endmodule

FILE: src/tlpt_dp.sv
// Datapath of the listen port table: entries, port compare, cursor, config and result registers.
module tlpt_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tlpt_pkg::tlpt_cmd_type                 cmd,
   output tlpt_pkg::tlpt_stat_type                stat,
   input  logic [1:0]                             req_opcode,
   input  logic [15:0]                            req_port_number,
   input  logic [7:0]                             req_handler_id,
   input  logic                                   csr_we,
   input  logic [tlpt_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [15:0]                            csr_wdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [2:0]                             rsp_status,
   output logic [7:0]                             rsp_found_handler,
   output logic [15:0]                            rsp_assigned_port
);
   import tlpt_pkg::*;

   logic [1:0]   op_ff;
   port_type     key_port_ff;
   handler_type  hdl_ff;
   port_type     eph_first_ff;
   port_type     eph_last_ff;
   port_type     cursor_ff;
   port_type     cursor_in;
   logic [16:0]  walk_cnt_ff;
   logic [16:0]  walk_cnt_in;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic [TABLE_ENTRIES-1:0] valid_in;
   port_type     entry_port_ff [TABLE_ENTRIES];
   handler_type  entry_handler_ff [TABLE_ENTRIES];

   logic [2:0]   res_status_ff, res_status_in;
   logic [7:0]   res_found_ff, res_found_in;
   port_type     res_assigned_ff, res_assigned_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [2:0]   rsp_status_ff;
   logic [7:0]   rsp_found_ff;
   port_type     rsp_assigned_ff;

   port_type     key;
   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic         hit_any;
   slot_type     hit_idx;
   slot_type     free_idx;
   logic         full;
   logic         range_bad;
   logic [16:0]  range;
   logic         cursor_in_range;
   logic         cand_bound;
   logic         last_cand;
   logic         bind_en;
   port_type     bind_port;

   assign key = cmd.walk_step ? cursor_ff : key_port_ff;

   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_vec[i] = valid_ff[i] && (entry_port_ff[i] == key);
      end
   end

   always_comb begin
      hit_idx = '0;
      free_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) hit_idx = SLOT_BITS'(i);
         if (!valid_ff[i]) free_idx = SLOT_BITS'(i);
      end
   end

   assign hit_any = |hit_vec;
   assign full = &valid_ff;
   assign range_bad = (eph_first_ff > eph_last_ff);
   assign range = {1'b0, eph_last_ff} - {1'b0, eph_first_ff} + 17'd1;
   assign cursor_in_range = (cursor_ff >= eph_first_ff) && (cursor_ff <= eph_last_ff);
   assign cand_bound = (cursor_ff == 16'd0) || hit_any;
   assign last_cand = ((walk_cnt_ff + 17'd1) == range);

   assign stat.walk_start = (op_ff == OP_LISTEN_ANY) && (hdl_ff != '0) && !range_bad;
   assign stat.walk_done = !cand_bound || last_cand;
   assign stat.out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      res_status_in = res_status_ff;
      res_found_in = res_found_ff;
      res_assigned_in = res_assigned_ff;
      valid_in = valid_ff;
      bind_en = 1'b0;
      bind_port = key_port_ff;
      cursor_in = cursor_ff;
      walk_cnt_in = walk_cnt_ff;
      if (cmd.exec) begin
         res_found_in = 8'd0;
         res_assigned_in = 16'd0;
         res_status_in = ST_OK;
         walk_cnt_in = 17'd0;
         unique case (op_ff)
            OP_LOOKUP: begin
               if (hit_any) res_found_in = 8'(32'(entry_handler_ff[hit_idx]));
            end
            OP_LISTEN: begin
               if (hdl_ff == '0 || key_port_ff == 16'd0) res_status_in = ST_INVALID;
               else if (hit_any) res_status_in = ST_IN_USE;
               else if (full) res_status_in = ST_FULL;
               else bind_en = 1'b1;
            end
            OP_LISTEN_ANY: begin
               if (hdl_ff == '0) res_status_in = ST_INVALID;
               else res_status_in = ST_NO_EPHEMERAL;
               if (stat.walk_start) cursor_in = cursor_in_range ? cursor_ff : eph_first_ff;
            end
            OP_UNLISTEN: begin
               if (hit_any) valid_in[hit_idx] = 1'b0;
            end
            default: res_status_in = ST_OK;
         endcase
      end
      if (cmd.walk_step) begin
         cursor_in = (cursor_ff == eph_last_ff) ? eph_first_ff : cursor_ff + 16'd1;
         walk_cnt_in = walk_cnt_ff + 17'd1;
         if (!cand_bound) begin
            if (full) begin
               res_status_in = ST_FULL;
            end else begin
               bind_en = 1'b1;
               bind_port = cursor_ff;
               res_status_in = ST_OK;
               res_assigned_in = cursor_ff;
            end
         end else if (last_cand) begin
            res_status_in = ST_NO_EPHEMERAL;
         end
      end
      if (bind_en) valid_in[free_idx] = 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cursor_ff <= EPH_FIRST_RESET;
         eph_first_ff <= EPH_FIRST_RESET;
         eph_last_ff <= EPH_LAST_RESET;
         rsp_valid_ff <= 1'b0;
         walk_cnt_ff <= 17'd0;
      end else begin
         valid_ff <= valid_in;
         cursor_ff <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_cnt_ff <= walk_cnt_in;
         if (csr_we && csr_index == CSR_EPH_FIRST) eph_first_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_EPH_LAST) eph_last_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff <= req_opcode;
         key_port_ff <= req_port_number;
         hdl_ff <= HANDLER_BITS'(32'(req_handler_id));
      end
      if (bind_en) begin
         entry_port_ff[free_idx] <= bind_port;
         entry_handler_ff[free_idx] <= hdl_ff;
      end
      res_status_ff <= res_status_in;
      res_found_ff <= res_found_in;
      res_assigned_ff <= res_assigned_in;
      if (cmd.load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_found_ff <= res_found_ff;
         rsp_assigned_ff <= res_assigned_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found_handler = rsp_found_ff;
   assign rsp_assigned_port = rsp_assigned_ff;

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |=> (cursor_ff >= eph_first_ff) && (cursor_ff <= eph_last_ff))
      else $error("ephemeral cursor left the range");

   a_walk_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (walk_cnt_ff < range))
      else $error("ephemeral walk ran past the range");

   a_assigned_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_assigned_ff != 16'd0) |->
         (rsp_status_ff == ST_OK && rsp_found_ff == 8'd0))
      else $error("assigned port on a failed or lookup result");

   a_bind_has_room: assert property (@(posedge clock) disable iff (reset)
      bind_en |-> (!full && hdl_ff != '0 && bind_port != 16'd0))
      else $error("bind into full table or with empty handler or port");

endmodule

FILE: src/tcp_listen_port_table_top.sv
// Top level of the TCP listen port table: request and result channels, register port.
//
// A table of up to TABLE_ENTRIES passive-open listeners, each a port and a nonzero handler id.
// Every request item gives exactly one result item. Items are handled one at a time.
// Lookup, listen and unlisten pass through the idle, exec and done states. Listen-any also
// passes a walk state between exec and done, where it tries N ephemeral candidates. One candidate
// is tried per cycle, through a single parallel port compare across all entries. N is at most
// TABLE_ENTRIES + 2 when port 0 lies in the range and TABLE_ENTRIES + 1 otherwise. N is never
// more than the range size. A new request is accepted while the previous result still waits
// in the output register. The next result then holds until that one is taken. The register
// port writes ephemeral_first (index 0) and ephemeral_last (index 1); other indexes are
// ignored. The user must see that registers are written only while the block is idle;
// the block itself does not enforce this. No clearing pass follows reset.
module tcp_listen_port_table_top (
   input  logic                                clock,
   input  logic                                reset,
   tlpt_req_if.sink                            req_bus,
   tlpt_rsp_if.source                          rsp_bus,
   input  logic                                csr_we,
   input  logic [tlpt_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [15:0]                         csr_wdata
);
   import tlpt_pkg::*;

   tlpt_cmd_type  cmd;
   tlpt_stat_type stat;

   tlpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tlpt_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_opcode        (req_bus.opcode),
      .req_port_number   (req_bus.port_number),
      .req_handler_id    (req_bus.handler_id),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_status        (rsp_bus.status),
      .rsp_found_handler (rsp_bus.found_handler),
      .rsp_assigned_port (rsp_bus.assigned_port)
   );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the TCP listen port table: random traffic with a built-in predictor.
module tb_top;
   import tlpt_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int PORT_POOL_SIZE = 20;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = CSR_INDEX_BITS'(3);

   typedef struct {
      logic [1:0]  opcode;
      port_type    port_number;
      logic [7:0]  handler_id;
      bit          drain_first;
   } listen_req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  found_handler;
      logic [15:0] assigned_port;
   } listen_rsp_type;

   typedef enum {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_mode_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [15:0] csr_wdata;

   tlpt_req_if req_bus();
   tlpt_rsp_if rsp_bus();

   tcp_listen_port_table_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   listen_req_type request_queue[$];
   listen_rsp_type reply_queue[$];

   bit          bound_valid[TABLE_ENTRIES];
   port_type    bound_port[TABLE_ENTRIES];
   handler_type bound_handler[TABLE_ENTRIES];
   port_type    cursor;
   port_type    range_first;
   port_type    range_last;

   port_type port_pool[PORT_POOL_SIZE];
   int gap_left;
   int burst_left;
   int mode_left;
   rx_mode_type rx_mode;
   int idle_cycles;
   int mismatch_count;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int slot_of(port_type port);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (bound_valid[i] && bound_port[i] == port) return i;
      return -1;
   endfunction

   function automatic int open_slot();
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (!bound_valid[i]) return i;
      return -1;
   endfunction

   function automatic void occupy(int slot, port_type port, handler_type hid);
      bound_valid[slot] = 1'b1;
      bound_port[slot] = port;
      bound_handler[slot] = hid;
   endfunction

   function automatic listen_rsp_type apply_request(listen_req_type rq);
      listen_rsp_type rep;
      handler_type hid;
      int slot;
      int unsigned span;
      int unsigned tries;
      bit searching;
      port_type cand;
      rep = '0;
      hid = rq.handler_id[HANDLER_BITS-1:0];
      case (rq.opcode)
         OP_LOOKUP: begin
            slot = slot_of(rq.port_number);
            if (slot >= 0) rep.found_handler = 8'(bound_handler[slot]);
         end
         OP_LISTEN: begin
            if (hid == 0 || rq.port_number == 0) rep.status = ST_INVALID;
            else if (slot_of(rq.port_number) >= 0) rep.status = ST_IN_USE;
            else begin
               slot = open_slot();
               if (slot < 0) rep.status = ST_FULL;
               else occupy(slot, rq.port_number, hid);
            end
         end
         OP_LISTEN_ANY: begin
            if (hid == 0) rep.status = ST_INVALID;
            else if (range_first > range_last) rep.status = ST_NO_EPHEMERAL;
            else begin
               rep.status = ST_NO_EPHEMERAL;
               span = {16'd0, range_last} - {16'd0, range_first} + 1;
               if (cursor < range_first || cursor > range_last) cursor = range_first;
               searching = 1'b1;
               tries = 0;
               while (searching && tries < span) begin
                  cand = cursor;
                  cursor = (cand == range_last) ? range_first : cand + 16'd1;
                  tries++;
                  if (cand != 0 && slot_of(cand) < 0) begin
                     searching = 1'b0;
                     slot = open_slot();
                     if (slot < 0) rep.status = ST_FULL;
                     else begin
                        occupy(slot, cand, hid);
                        rep.status = ST_OK;
                        rep.assigned_port = cand;
                     end
                  end
               end
            end
         end
         default: begin
            slot = slot_of(rq.port_number);
            if (slot >= 0) bound_valid[slot] = 1'b0;
         end
      endcase
      return rep;
   endfunction

   function automatic listen_req_type random_request(bit filling);
      listen_req_type rq;
      int pick;
      int hsel;
      pick = $urandom_range(0, 99);
      if (filling)
         rq.opcode = (pick < 30) ? OP_LISTEN : (pick < 55) ? OP_LISTEN_ANY :
                     (pick < 70) ? OP_UNLISTEN : OP_LOOKUP;
      else
         rq.opcode = (pick < 15) ? OP_LISTEN : (pick < 25) ? OP_LISTEN_ANY :
                     (pick < 70) ? OP_UNLISTEN : OP_LOOKUP;
      case ($urandom_range(0, 9))
         0: rq.port_number = port_type'($urandom_range(0, 65535));
         1: rq.port_number = range_first + port_type'($urandom_range(0, 20));
         default: rq.port_number = port_pool[$urandom_range(0, PORT_POOL_SIZE - 1)];
      endcase
      hsel = $urandom_range(0, 19);
      rq.handler_id = (hsel == 0) ? 8'd0 : (hsel == 1) ? 8'd255 : 8'($urandom_range(1, 255));
      rq.drain_first = ($urandom_range(0, 59) == 0);
      return rq;
   endfunction

   function automatic void add_request(logic [1:0] op, port_type port, logic [7:0] hid);
      listen_req_type rq;
      rq.opcode = op;
      rq.port_number = port;
      rq.handler_id = hid;
      rq.drain_first = 1'b0;
      request_queue.push_back(rq);
   endfunction

   function automatic void add_random(int count);
      listen_req_type rq;
      for (int n = 0; n < count; n++) begin
         rq = random_request(((n / 50) % 2) == 0);
         // hold the first item of a phase until all earlier replies are back
         if (n == 0) rq.drain_first = 1'b1;
         request_queue.push_back(rq);
      end
   endfunction

   function automatic void log_mismatch(string what, listen_rsp_type got, listen_rsp_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s: status %0d (exp %0d) handler %0d (exp %0d) port %0d (exp %0d)",
                  $time, what, got.status, want.status, got.found_handler,
                  want.found_handler, got.assigned_port, want.assigned_port);
   endfunction

   task automatic wait_idle();
      while (request_queue.size() != 0 || reply_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, port_type value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_EPH_FIRST) range_first = value;
      else if (idx == CSR_EPH_LAST) range_last = value;
   endtask

   task automatic set_range(port_type first_port, port_type last_port);
      wait_idle();
      repeat (4) @(posedge clock);
      write_csr(CSR_EPH_FIRST, first_port);
      write_csr(CSR_EPH_LAST, last_port);
   endtask

   // request driver
   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            reply_queue.push_back(apply_request(request_queue.pop_front()));
         if (!req_bus.valid || req_bus.ready) begin
            offer = 1'b0;
            if (gap_left > 0) gap_left--;
            else if (request_queue.size() > 0 &&
                     !(request_queue[0].drain_first && reply_queue.size() > 0)) begin
               offer = 1'b1;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(0, 8);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               end
            end
            req_bus.valid <= offer;
            if (offer) begin
               req_bus.opcode <= request_queue[0].opcode;
               req_bus.port_number <= request_queue[0].port_number;
               req_bus.handler_id <= request_queue[0].handler_id;
            end
         end
      end
   end

   // reply backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         mode_left = 0;
      end else begin
         if (mode_left == 0) begin
            rx_mode = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         case (rx_mode)
            RX_OPEN:         rsp_bus.ready <= 1'b1;
            RX_COIN:         rsp_bus.ready <= ($urandom_range(0, 1) == 1);
            RX_EVERY_FOURTH: rsp_bus.ready <= (mode_left % 4 == 0);
            default:         rsp_bus.ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // reply monitor
   always @(posedge clock) begin
      listen_rsp_type got;
      listen_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status = rsp_bus.status;
         got.found_handler = rsp_bus.found_handler;
         got.assigned_port = rsp_bus.assigned_port;
         if (reply_queue.size() == 0) log_mismatch("unexpected item", got, '0);
         else begin
            want = reply_queue.pop_front();
            if (got.status !== want.status || got.found_handler !== want.found_handler ||
                got.assigned_port !== want.assigned_port)
               log_mismatch("mismatch", got, want);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_EPH_FIRST;
      csr_wdata = 16'd0;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_LOOKUP;
      req_bus.port_number = 16'd0;
      req_bus.handler_id = 8'd0;
      rsp_bus.ready = 1'b0;
      idle_cycles = 0;
      mismatch_count = 0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         bound_valid[i] = 1'b0;
         bound_port[i] = 16'd0;
         bound_handler[i] = '0;
      end
      range_first = EPH_FIRST_RESET;
      range_last = EPH_LAST_RESET;
      cursor = EPH_FIRST_RESET;
      port_pool[0] = 16'd1;
      port_pool[1] = 16'd65535;
      port_pool[2] = 16'd0;
      port_pool[3] = 16'h8000;
      for (int i = 4; i < PORT_POOL_SIZE; i++) port_pool[i] = port_type'($urandom_range(1, 65535));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_request(OP_LOOKUP, 16'd0, 8'd0);
      add_request(OP_LISTEN, 16'd5, 8'd0);
      add_request(OP_LISTEN, 16'd0, 8'd7);
      add_request(OP_LISTEN, 16'd65535, 8'd255);
      add_request(OP_LISTEN, 16'd65535, 8'd1);
      add_request(OP_LISTEN_ANY, 16'd0, 8'd0);
      add_request(OP_LISTEN_ANY, 16'd65535, 8'd128);
      add_request(OP_UNLISTEN, 16'd1234, 8'd0);
      add_request(OP_UNLISTEN, 16'd65535, 8'd0);
      // fill the table through the ephemeral range
      for (int i = 1; i <= 15; i++) add_request(OP_LISTEN_ANY, 16'(i * 4099), 8'(i * 17));
      add_request(OP_LISTEN, 16'h5A5A, 8'h5A);
      add_request(OP_LISTEN, 16'd49153, 8'd3);
      add_request(OP_LISTEN_ANY, 16'd0, 8'd1);
      add_random(250);

      set_range(16'd100, 16'd105);
      add_random(150);
      set_range(16'd0, 16'd3);
      add_random(80);
      set_range(16'd500, 16'd400);
      write_csr(CSR_SPARE_LO, 16'hA5C3);
      write_csr(CSR_SPARE_HI, 16'hFFFF);
      add_random(60);
      set_range(16'd65535, 16'd65535);
      add_random(60);
      set_range(16'd1, 16'd65535);
      add_random(150);
      set_range(16'd40000, 16'd40020);
      add_random(200);

      wait_idle();
      repeat (24) @(posedge clock);
      if (mismatch_count == 0 && reply_queue.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule
